// ===== sv/pgh_pkg.sv =====
// shared constants for the periodic particle grid histogram unit
`timescale 1ns / 1ps
package pgh_pkg;

   localparam int CELLS_DEFAULT         = 16384;
   localparam int FRACTION_BITS_DEFAULT = 24;
   localparam int COUNT_BITS_DEFAULT    = 32;

   localparam int POS_BITS    = 26;
   localparam int INDEX_BITS  = 14;
   localparam int OUT_BITS    = 32;
   localparam int GRID_BITS   = 8;
   localparam int CSR_IDX_BITS = 4;

   localparam logic [GRID_BITS-1:0] GRID_MAX   = 8'd128;
   localparam logic [GRID_BITS-1:0] GRID_RESET = 8'd100;

   localparam logic [1:0] KIND_DEPOSIT    = 2'd0;
   localparam logic [1:0] KIND_READ       = 2'd1;
   localparam logic [1:0] KIND_READ_CLEAR = 2'd2;
   localparam logic [1:0] KIND_UNUSED     = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_HEIGHT = 4'd1;

endpackage

// ===== sv/periodic_particle_grid_histogram_unit.sv =====
// top level: nearest grid point deposit histogram on a periodic unit square
// a read result passes the stage 1, stage 2 and result registers before it appears on rsp_
// throughput: one beat per cycle while busy is low, set by the single read-modify-write pipeline
//   on the counter memory with one level of write-to-read forwarding
// reset: busy stays high while the clearing pass zeroes the
//   counter memory one entry a cycle; csr writes are taken throughout
`timescale 1ns / 1ps
module periodic_particle_grid_histogram_unit
   import pgh_pkg::*;
#(
   parameter int CELLS         = CELLS_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   parameter int COUNT_BITS    = COUNT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_kind,
   input  logic signed [POS_BITS-1:0]     req_pos_x,
   input  logic signed [POS_BITS-1:0]     req_pos_y,
   input  logic [INDEX_BITS-1:0]          req_cell_index,
   output logic                           rsp_valid,
   output logic [OUT_BITS-1:0]            rsp_cell_count,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_BITS-1:0]        csr_index,
   input  logic [GRID_BITS-1:0]           csr_data
);

   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int FW    = (FRACTION_BITS < POS_BITS) ? FRACTION_BITS : POS_BITS;
   localparam int PW    = FW + GRID_BITS;
   localparam int IW    = 2 * GRID_BITS;
   localparam int XW    = ((AW > IW) ? AW : IW) + 2;
   localparam int CW    = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

   logic [GRID_BITS-1:0] grid_width_ff, grid_height_ff;
   logic [GRID_BITS-1:0] size_w, size_h;

   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   logic [COUNT_BITS-1:0] mem [CELLS];
   logic [COUNT_BITS-1:0] rdata_ff;

   logic                  s1_valid_ff;
   logic [1:0]            s1_kind_ff;
   logic [GRID_BITS-1:0]  s1_ix_ff, s1_iy_ff;
   logic [INDEX_BITS-1:0] s1_index_ff;
   logic [XW-1:0]         s1_wide;
   logic [AW-1:0]         s1_addr;
   logic                  s1_in_range;

   logic                  s2_valid_ff;
   logic [1:0]            s2_kind_ff;
   logic [AW-1:0]         s2_addr_ff;
   logic                  s2_in_range_ff;
   logic                  fwd_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [COUNT_BITS-1:0] s2_old;
   logic [COUNT_BITS-1:0] s2_new;
   logic                  s2_we;
   logic                  s2_is_read;
   logic [CW-1:0]         s2_result;

   logic                  rsp_valid_ff;
   logic [OUT_BITS-1:0]   rsp_cell_count_ff;

   logic [FW-1:0]         frac_x, frac_y;
   logic [PW-1:0]         prod_x, prod_y;
   logic                  accept;

   assign busy      = clr_active_ff;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // grid size clamped into 1..128
   always_comb begin
      size_w = grid_width_ff;
      size_h = grid_height_ff;
      if (grid_width_ff == '0) size_w = GRID_BITS'(1);
      else if (grid_width_ff > GRID_MAX) size_w = GRID_MAX;
      if (grid_height_ff == '0) size_h = GRID_BITS'(1);
      else if (grid_height_ff > GRID_MAX) size_h = GRID_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_RESET;
         grid_height_ff <= GRID_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_GRID_WIDTH) grid_width_ff <= csr_data;
         if (csr_index == CSR_GRID_HEIGHT) grid_height_ff <= csr_data;
      end
   end

   // clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(CELLS - 1)) clr_active_ff <= 1'b0;
      end
   end

   // stage 0: wrap and scale each coordinate
   assign frac_x = req_pos_x[FW-1:0];
   assign frac_y = req_pos_y[FW-1:0];
   assign prod_x = PW'(frac_x) * PW'(size_w);
   assign prod_y = PW'(frac_y) * PW'(size_h);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && (req_kind != KIND_UNUSED);
      end
      s1_kind_ff  <= req_kind;
      s1_ix_ff    <= GRID_BITS'(prod_x >> FRACTION_BITS);
      s1_iy_ff    <= GRID_BITS'(prod_y >> FRACTION_BITS);
      s1_index_ff <= req_cell_index;
   end

   // stage 1: cell address and memory read
   always_comb begin
      if (s1_kind_ff == KIND_DEPOSIT) begin
         s1_wide = XW'(IW'(s1_iy_ff) * IW'(size_w)) + XW'(s1_ix_ff);
      end else begin
         s1_wide = XW'(s1_index_ff);
      end
      s1_in_range = s1_wide < XW'(CELLS);
      s1_addr     = s1_wide[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         fwd_ff      <= s1_valid_ff && s2_we && (s1_addr == s2_addr_ff);
      end
      s2_kind_ff     <= s1_kind_ff;
      s2_addr_ff     <= s1_addr;
      s2_in_range_ff <= s1_in_range;
      fwd_data_ff    <= s2_new;
   end

   // stage 2: modify and write back
   always_comb begin
      s2_old     = fwd_ff ? fwd_data_ff : rdata_ff;
      s2_is_read = (s2_kind_ff == KIND_READ) || (s2_kind_ff == KIND_READ_CLEAR);
      s2_we      = s2_valid_ff && s2_in_range_ff && (s2_kind_ff != KIND_READ);
      if (s2_kind_ff == KIND_DEPOSIT) begin
         s2_new = (s2_old == '1) ? s2_old : s2_old + COUNT_BITS'(1);
      end else begin
         s2_new = '0;
      end
      s2_result = s2_in_range_ff ? CW'(s2_old) : '0;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[s1_addr];
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (s2_we) begin
         mem[s2_addr_ff] <= s2_new;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff && s2_is_read;
      end
      rsp_cell_count_ff <= s2_result[OUT_BITS-1:0];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_count = rsp_cell_count_ff;

endmodule

// ===== sv/pgh_checker.sv =====
// port-level checks for the periodic particle grid histogram unit
`timescale 1ns / 1ps
module pgh_checker
   import pgh_pkg::*;
#(
   parameter int CELLS = CELLS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [1:0]            req_kind,
   input logic [INDEX_BITS-1:0] req_cell_index,
   input logic                  rsp_valid,
   input logic [OUT_BITS-1:0]   rsp_cell_count
);

   logic rd_beat;
   assign rd_beat = start && !busy && (req_kind == KIND_READ || req_kind == KIND_READ_CLEAR);

   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("clearing pass not started after reset");

   a_read_gives_result: assert property (@(posedge clock) disable iff (reset)
      rd_beat |-> ##3 rsp_valid)
      else $error("read beat without result");

   a_result_has_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(rd_beat, 3))
      else $error("result without read beat");

   a_cleared_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_READ_CLEAR && (req_cell_index < CELLS))
      ##1 (rd_beat && req_cell_index == $past(req_cell_index))
      |-> ##3 (rsp_cell_count == '0))
      else $error("cell not zero after read and clear");

endmodule

bind periodic_particle_grid_histogram_unit pgh_checker #(.CELLS(CELLS)) u_pgh_checker (.*);

// ===== sim/periodic_particle_grid_histogram_unit_tb.sv =====
// testbench for the periodic particle grid histogram unit: directed and random deposits and reads checked
`timescale 1ns / 1ps
module periodic_particle_grid_histogram_unit_tb;
   import pgh_pkg::*;

   localparam int FRAC_BITS    = FRACTION_BITS_DEFAULT;
   localparam int CELL_COUNT   = CELLS_DEFAULT;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int ITEM_TARGET  = 1600;
   localparam int PHASES       = 11;
   localparam logic [OUT_BITS-1:0] COUNT_MAX = '1;

   class histogram_scoreboard;
      logic [OUT_BITS-1:0]  counts [CELL_COUNT];
      logic [OUT_BITS-1:0]  expected_counts [$];
      logic [GRID_BITS-1:0] width_reg;
      logic [GRID_BITS-1:0] height_reg;
      int unsigned          touched [$];
      int                   mismatches;
      int                   checked;
      int                   deposits;
      int                   reads;
      int                   clears;

      function new();
         foreach (counts[i]) counts[i] = '0;
         width_reg  = GRID_RESET;
         height_reg = GRID_RESET;
         mismatches = 0;
         checked    = 0;
         deposits   = 0;
         reads      = 0;
         clears     = 0;
      endfunction

      function int unsigned grid_size(logic [GRID_BITS-1:0] r);
         if (r == 0) return 1;
         if (r > GRID_MAX) return GRID_MAX;
         return r;
      endfunction

      function int unsigned axis_cell(logic [POS_BITS-1:0] p, int unsigned size);
         longint unsigned frac;
         longint unsigned scaled;
         frac   = p[FRAC_BITS-1:0];
         scaled = frac * size;
         return int'(scaled >> FRAC_BITS);
      endfunction

      function int unsigned active_cells();
         return grid_size(width_reg) * grid_size(height_reg);
      endfunction

      function int unsigned recent_cell();
         if (touched.size() == 0) return 0;
         return touched[$urandom_range(0, touched.size() - 1)];
      endfunction

      function void set_register(logic [CSR_IDX_BITS-1:0] idx, logic [GRID_BITS-1:0] data);
         if (idx == CSR_GRID_WIDTH) width_reg = data;
         else if (idx == CSR_GRID_HEIGHT) height_reg = data;
      endfunction

      function void note_beat(logic [1:0] kind, logic [POS_BITS-1:0] x,
                              logic [POS_BITS-1:0] y, logic [INDEX_BITS-1:0] idx);
         int unsigned w;
         int unsigned cell_num;
         logic [OUT_BITS-1:0] value;
         if (kind == KIND_DEPOSIT) begin
            w        = grid_size(width_reg);
            cell_num = axis_cell(y, grid_size(height_reg)) * w + axis_cell(x, w);
            deposits++;
            if (cell_num < CELL_COUNT) begin
               if (counts[cell_num] != COUNT_MAX) counts[cell_num] = counts[cell_num] + 1;
               touched.push_back(cell_num);
               if (touched.size() > 32) void'(touched.pop_front());
            end
         end else if (kind == KIND_READ || kind == KIND_READ_CLEAR) begin
            value = '0;
            if (idx < CELL_COUNT) begin
               value = counts[idx];
               if (kind == KIND_READ_CLEAR) counts[idx] = '0;
            end
            if (kind == KIND_READ_CLEAR) clears++;
            else reads++;
            expected_counts.push_back(value);
         end
      endfunction

      function void report(string what, logic [OUT_BITS-1:0] exp_v, logic [OUT_BITS-1:0] act_v);
         mismatches++;
         if (mismatches <= 10)
            $display("error at %0t: %s, cell_count expected %0d actual %0d",
                     $realtime, what, exp_v, act_v);
      endfunction

      function void check_count(logic [OUT_BITS-1:0] actual);
         logic [OUT_BITS-1:0] exp_v;
         if (expected_counts.size() == 0) begin
            report("result with no read pending", '0, actual);
            return;
         end
         exp_v = expected_counts.pop_front();
         checked++;
         if (actual !== exp_v) report("wrong count", exp_v, actual);
      endfunction

      function void finish_check();
         while (expected_counts.size() != 0)
            report("read never answered", expected_counts.pop_front(), '0);
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [1:0]                  req_kind;
   logic signed [POS_BITS-1:0]  req_pos_x;
   logic signed [POS_BITS-1:0]  req_pos_y;
   logic [INDEX_BITS-1:0]       req_cell_index;
   logic                        rsp_valid;
   logic [OUT_BITS-1:0]         rsp_cell_count;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_BITS-1:0]     csr_index;
   logic [GRID_BITS-1:0]        csr_data;

   histogram_scoreboard sb;
   int                  cycle_count = 0;
   int                  burst_left;
   int                  items_sent;
   int                  settings_used;
   logic [POS_BITS-1:0] pool_x [$];
   logic [POS_BITS-1:0] pool_y [$];

   periodic_particle_grid_histogram_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_cell_count (rsp_cell_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_count(rsp_cell_count);
   end

   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [POS_BITS-1:0] draw_position();
      if ($urandom_range(0, 6) == 0) return POS_BITS'($urandom);
      return POS_BITS'($urandom_range(0, 50331647) - 16777216);
   endfunction

   // one request beat; called and returns at a falling edge
   task automatic drive_beat(logic [1:0] kind, logic [POS_BITS-1:0] x,
                             logic [POS_BITS-1:0] y, logic [INDEX_BITS-1:0] idx, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_kind       <= kind;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_cell_index <= idx;
      do @(posedge clock); while (busy);
      sb.note_beat(kind, x, y, idx);
      if (kind != KIND_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx, logic [GRID_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clock);
   endtask

   // drop start, drain pending reads, then let in-flight deposits retire
   task automatic settle();
      start <= 1'b0;
      while (sb.expected_counts.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic random_item();
      int unsigned         pick;
      int unsigned         cells;
      logic [1:0]          kind;
      logic [POS_BITS-1:0] x;
      logic [POS_BITS-1:0] y;
      logic [INDEX_BITS-1:0] idx;
      pick = $urandom_range(0, 99);
      x    = draw_position();
      y    = draw_position();
      idx  = INDEX_BITS'($urandom);
      if (pick < 6) begin
         kind = KIND_UNUSED;
      end else if (pick < 60) begin
         kind = KIND_DEPOSIT;
         if (pool_x.size() != 0 && $urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, pool_x.size() - 1);
            x    = pool_x[pick];
            y    = pool_y[pick];
         end else if (pool_x.size() < 6) begin
            pool_x.push_back(x);
            pool_y.push_back(y);
         end
      end else begin
         kind  = ($urandom_range(0, 9) < 3) ? KIND_READ_CLEAR : KIND_READ;
         cells = sb.active_cells();
         pick  = $urandom_range(0, 9);
         if (pick < 6) idx = INDEX_BITS'(sb.recent_cell());
         else if (pick < 9) idx = INDEX_BITS'($urandom_range(0, cells - 1));
      end
      drive_beat(kind, x, y, idx, draw_gap());
   endtask

   initial begin
      logic [GRID_BITS-1:0] widths  [7];
      logic [GRID_BITS-1:0] heights [7];
      int                   per_phase;
      widths  = '{8'd1, 8'd128, 8'd0,   8'd7, 8'd200, 8'd255, 8'd16};
      heights = '{8'd1, 8'd128, 8'd255, 8'd3, 8'd129, 8'd0,   8'd100};
      sb             = new();
      burst_left     = 0;
      items_sent     = 0;
      settings_used  = 1;
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = KIND_DEPOSIT;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_cell_index = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_GRID_WIDTH;
      csr_data       = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (busy) @(negedge clock);

      // corners, wrap-around, ignored kind, top index, clear then reread
      drive_beat(KIND_DEPOSIT, 26'd0, 26'd0, 14'd0, 0);
      drive_beat(KIND_DEPOSIT, 26'd0, 26'd0, 14'd0, 0);
      drive_beat(KIND_READ, 26'd0, 26'd0, 14'd0, 0);
      drive_beat(KIND_DEPOSIT, 26'h1FFFFFF, 26'h1FFFFFF, 14'd0, 1);
      drive_beat(KIND_DEPOSIT, -26'sd16777216, -26'sd1, 14'd0, 0);
      drive_beat(KIND_DEPOSIT, 26'h2000000, 26'd16777216, 14'd0, 0);
      drive_beat(KIND_READ_CLEAR, 26'd0, 26'd0, 14'd0, 0);
      drive_beat(KIND_READ, 26'd0, 26'd0, 14'd0, 0);
      drive_beat(KIND_READ, 26'd0, 26'd0, 14'd9999, 2);
      drive_beat(KIND_READ, 26'd0, 26'd0, 14'd9900, 0);
      drive_beat(KIND_UNUSED, 26'h3FFFFFF, 26'h3FFFFFF, 14'h3FFF, 0);
      drive_beat(KIND_READ, 26'd0, 26'd0, 14'h3FFF, 0);
      drive_beat(KIND_READ_CLEAR, 26'd0, 26'd0, 14'h3FFF, 3);
      drive_beat(KIND_DEPOSIT, 26'h0800000, 26'h0800000, 14'd0, 0);
      drive_beat(KIND_READ_CLEAR, 26'd0, 26'd0, 14'd5050, 0);
      drive_beat(KIND_READ, 26'd0, 26'd0, 14'd5050, 0);
      drive_beat(KIND_READ_CLEAR, 26'd0, 26'd0, 14'd9999, 0);

      per_phase = (ITEM_TARGET - items_sent) / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         if ($urandom_range(0, 1) == 0)
            write_register(CSR_IDX_BITS'($urandom_range(CSR_GRID_HEIGHT + 1, 15)),
                           GRID_BITS'($urandom));
         if (p < 7) begin
            write_register(CSR_GRID_WIDTH, widths[p]);
            write_register(CSR_GRID_HEIGHT, heights[p]);
         end else begin
            write_register(CSR_GRID_WIDTH, GRID_BITS'($urandom_range(0, 255)));
            write_register(CSR_GRID_HEIGHT, GRID_BITS'($urandom_range(0, 255)));
         end
         settings_used++;
         pool_x.delete();
         pool_y.delete();
         while (items_sent < ITEM_TARGET - (PHASES - 1 - p) * per_phase) random_item();
      end

      settle();
      repeat (10) @(posedge clock);
      sb.finish_check();
      $display("%0d beats over %0d grid settings: %0d deposits, %0d reads, %0d clearing reads",
               items_sent, settings_used, sb.deposits, sb.reads, sb.clears);
      $display("%0d counts checked, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/pgh_pkg.sv
sv/periodic_particle_grid_histogram_unit.sv
sv/pgh_checker.sv
sim/periodic_particle_grid_histogram_unit_tb.sv
